>>> rtl/slfr_pkg.sv
// ============================================================================
// slfr_pkg
// Shared types and constants for the sync/length frame receiver.
// ============================================================================
package slfr_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 256;

    localparam int BYTE_W   = 8;
    localparam int TOTAL_W  = 17;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SYNC_VALUE = 1'b0;

    // frame layout
    localparam int POS_LEN_LO = 2;
    localparam int POS_LEN_HI = 3;
    localparam int LEN_OFFSET = 5;

    typedef struct packed {
        logic              accepted;
        logic [BYTE_W-1:0] position;
        logic [BYTE_W-1:0] byte_out;
        logic              frame_done;
        logic              overflow;
    } result_t;

endpackage

>>> rtl/slfr_cfg.sv
// ============================================================================
// slfr_cfg
// APB register file: holds the sync byte value.
// ============================================================================
module slfr_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [slfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [slfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [slfr_pkg::BYTE_W-1:0]      sync_value
);
    import slfr_pkg::*;

    logic [BYTE_W-1:0] sync_value_reg;
    logic [BYTE_W-1:0] sync_value_next;
    logic              wr_sync;

    assign pready  = 1'b1;
    assign wr_sync = psel && penable && pwrite && (paddr[2] == REG_SYNC_VALUE);

    always_comb
    begin
        sync_value_next = sync_value_reg;
        if (wr_sync)
        begin
            sync_value_next = pwdata[BYTE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg <= '0;
        end
        else
        begin
            sync_value_reg <= sync_value_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SYNC_VALUE)
        begin
            prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, sync_value_reg};
        end
    end

    assign sync_value = sync_value_reg;

endmodule

>>> rtl/slfr_deframe.sv
// ============================================================================
// slfr_deframe
// Frame tracking state and per-word result logic.
// ============================================================================
module slfr_deframe
#(
    parameter int BUFFER_BYTES = slfr_pkg::BUFFER_BYTES_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [slfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic [slfr_pkg::BYTE_W-1:0] sync_value,
    output slfr_pkg::result_t           result
);
    import slfr_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_BYTES + 1);

    logic               in_frame_reg,   in_frame_next;
    logic [IDX_W-1:0]   widx_reg,       widx_next;
    logic [TOTAL_W-1:0] total_reg,      total_next;
    logic [BYTE_W-1:0]  len_lo_reg,     len_lo_next;

    logic [IDX_W-1:0]   widx_inc;
    logic [TOTAL_W-1:0] total_cur;
    logic               done;
    logic               full;

    assign widx_inc = widx_reg + IDX_W'(1);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        widx_next     = widx_reg;
        total_next    = total_reg;
        len_lo_next   = len_lo_reg;
        total_cur     = total_reg;
        done          = 1'b0;
        full          = 1'b0;
        result        = '0;

        if (!in_frame_reg)
        begin
            if (rx_byte == sync_value)
            begin
                in_frame_next   = 1'b1;
                widx_next       = IDX_W'(1);
                total_next      = '0;
                result.accepted = 1'b1;
                result.byte_out = rx_byte;
            end
        end
        else
        begin
            if (widx_reg == IDX_W'(POS_LEN_LO))
            begin
                len_lo_next = rx_byte;
            end
            if (widx_reg == IDX_W'(POS_LEN_HI))
            begin
                total_cur = {1'b0, rx_byte, len_lo_reg} + TOTAL_W'(LEN_OFFSET);
            end
            done = (total_cur != '0) && (TOTAL_W'(widx_inc) >= total_cur);
            full = (widx_inc == IDX_W'(BUFFER_BYTES));

            total_next    = total_cur;
            in_frame_next = !(done || full);
            widx_next     = full ? '0 : widx_inc;

            result.accepted   = 1'b1;
            result.position   = BYTE_W'(widx_reg);
            result.byte_out   = rx_byte;
            result.frame_done = done;
            result.overflow   = full && !done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            widx_reg     <= '0;
            total_reg    <= '0;
        end
        else if (step)
        begin
            in_frame_reg <= in_frame_next;
            widx_reg     <= widx_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            len_lo_reg <= len_lo_next;
        end
    end

endmodule

>>> rtl/sync_length_frame_receiver_unit.sv
// ============================================================================
// sync_length_frame_receiver_unit
// Deframer for sync-prefixed, length-prefixed byte frames.
// ============================================================================
// Input stream (s_*): one received byte per word. Output stream (m_*): one
// word per input word. Bytes are dropped (accepted = 0, all fields zero)
// until a byte equal to the sync register arrives; that byte is position 0.
// Bytes at positions 2 and 3 give a little-endian length L, the frame is
// L + 5 bytes long, and its last byte carries m_tlast. A frame reaching
// BUFFER_BYTES bytes without completing ends with the overflow flag.
// Each accepted byte passes the input register, then the result register
// that drives m_tvalid. Throughput: one word per cycle while m_tready is
// high; the frame state update between the registers is a single add and compare.
// s_tready stays high while the result register is free or being drained,
// so a waiting result does not block the next input. When m_tready is low
// both registers fill and s_tready drops; nothing is lost or duplicated.
// Reset clears both valid flags, the frame state and the sync register.
// The sync register (byte address 0) must be written only while idle.
// ============================================================================
module sync_length_frame_receiver_unit
#(
    parameter int BUFFER_BYTES = slfr_pkg::BUFFER_BYTES_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [slfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [slfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [7:0] position, [15:8] byte_out
    output logic                             m_tlast,   // frame_done
    output logic [1:0]                       m_tuser    // [0] accepted, [1] overflow
);
    import slfr_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic              advance;
    logic              s_take;
    logic [BYTE_W-1:0] sync_value;
    result_t           result;

    slfr_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sync_value (sync_value)
    );

    slfr_deframe #(.BUFFER_BYTES(BUFFER_BYTES)) u_deframe
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .sync_value (sync_value),
        .result     (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.byte_out, out_reg.position};
    assign m_tlast  = out_reg.frame_done;
    assign m_tuser  = {out_reg.overflow, out_reg.accepted};

`ifndef SYNTHESIS
    a_done_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0] && !m_tuser[1])
        else $error("frame end on a rejected byte or with overflow");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == 16'd0) && !m_tlast && !m_tuser[1])
        else $error("rejected byte carries nonzero fields");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register lost a word");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result register not loaded");
`endif

endmodule
